[sv/dpvg_pkg.sv]
package dpvg_pkg;

  localparam int PcW = 6;

  // Program layout
  localparam logic [PcW-1:0] EntryNext  = 6'd0;   // coordinate k >= 1
  localparam logic [PcW-1:0] EntryTail  = 6'd33;  // closing beats of a point
  localparam logic [PcW-1:0] EntryFirst = 6'd35;  // coordinate k == 0
  localparam logic [PcW-1:0] PcLast     = 6'd45;

  typedef enum logic [3:0] {
    LD_NONE,
    LD_XX,
    LD_D0SQ,
    LD_D0_2,
    LD_T_2W,
    LD_T_W,
    LD_TW_T,
    LD_X_8W,
    LD_XW_T
  } ld_e;

  typedef enum logic [1:0] {
    POST_NONE,
    POST_RND,
    POST_SAT
  } post_e;

  // Rounding shift: F-16, 2F-16, 3F-16 or 4F-16 fraction bits dropped
  typedef enum logic [1:0] {
    RS_F1,
    RS_F2,
    RS_F3,
    RS_F4
  } rsel_e;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_TERM,
    DST_GOUT,
    DST_SUM_SET,
    DST_SUM_ADD,
    DST_PEND_SET,
    DST_ADVANCE,
    DST_OUT_PEND,
    DST_OUT_SUM
  } dst_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JEND,
    SEQ_DONE
  } seq_e;

  typedef struct packed {
    ld_e            ld;
    logic           mul_en;
    logic           mul_i;
    logic           mul_j;
    logic           acc_en;
    logic [1:0]     acc_sh;
    post_e          post;
    rsel_e          rsel;
    dst_e           dst;
    seq_e           seq;
    logic [PcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic       ld_en;
    logic       mul_en;
    logic       mul_i;
    logic       mul_j;
    logic       acc_en;
    logic [1:0] acc_sh;
    post_e      post;
    rsel_e      rsel;
  } mac_ctrl_t;

  localparam ucode_t UwNop = '{
    ld:     LD_NONE,
    mul_en: 1'b0,
    mul_i:  1'b0,
    mul_j:  1'b0,
    acc_en: 1'b0,
    acc_sh: 2'd0,
    post:   POST_NONE,
    rsel:   RS_F1,
    dst:    DST_NONE,
    seq:    SEQ_NEXT,
    target: '0
  };

  // Control store. A multiply issued in one word is accumulated in the next.
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t u;
    u = UwNop;
    case (pc)
      // t = 2*x^2 - prev*2^F
      6'd0:  u.ld = LD_XX;
      6'd1:  u.mul_en = 1'b1;
      6'd2:  u.acc_en = 1'b1;
      6'd3:  u.dst = DST_TERM;
      // t * -2w, then g(k-1)
      6'd4:  u.ld = LD_T_2W;
      6'd5:  u.mul_en = 1'b1;
      6'd6:  begin
        u.mul_en = 1'b1; u.mul_i = 1'b1; u.acc_en = 1'b1;
      end
      6'd7:  begin
        u.acc_en = 1'b1; u.acc_sh = 2'd1;
      end
      6'd8:  begin
        u.post = POST_RND; u.rsel = RS_F2;
      end
      6'd9:  begin
        u.post = POST_SAT; u.ld = LD_T_W;
      end
      // |t|*w while g(k-1) goes out
      6'd10: begin
        u.mul_en = 1'b1; u.dst = DST_GOUT;
      end
      6'd11: begin
        u.mul_en = 1'b1; u.mul_i = 1'b1; u.acc_en = 1'b1;
      end
      6'd12: begin
        u.acc_en = 1'b1; u.acc_sh = 2'd1;
      end
      // (t*w)*t into the sum
      6'd13: u.ld = LD_TW_T;
      6'd14: u.mul_en = 1'b1;
      6'd15: begin
        u.mul_en = 1'b1; u.mul_j = 1'b1; u.acc_en = 1'b1;
      end
      6'd16: begin
        u.mul_en = 1'b1; u.mul_i = 1'b1; u.acc_en = 1'b1; u.acc_sh = 2'd1;
      end
      6'd17: begin
        u.mul_en = 1'b1; u.mul_i = 1'b1; u.mul_j = 1'b1;
        u.acc_en = 1'b1; u.acc_sh = 2'd1;
      end
      6'd18: begin
        u.acc_en = 1'b1; u.acc_sh = 2'd2;
      end
      6'd19: begin
        u.post = POST_RND; u.rsel = RS_F4;
      end
      6'd20: begin
        u.post = POST_SAT; u.ld = LD_X_8W;
      end
      6'd21: begin
        u.mul_en = 1'b1; u.dst = DST_SUM_ADD;
      end
      6'd22: u.acc_en = 1'b1;
      // (x*8w)*t becomes the pending gradient part
      6'd23: u.ld = LD_XW_T;
      6'd24: u.mul_en = 1'b1;
      6'd25: begin
        u.mul_en = 1'b1; u.mul_j = 1'b1; u.acc_en = 1'b1;
      end
      6'd26: begin
        u.mul_en = 1'b1; u.mul_i = 1'b1; u.acc_en = 1'b1; u.acc_sh = 2'd1;
      end
      6'd27: begin
        u.mul_en = 1'b1; u.mul_i = 1'b1; u.mul_j = 1'b1;
        u.acc_en = 1'b1; u.acc_sh = 2'd1;
      end
      6'd28: begin
        u.acc_en = 1'b1; u.acc_sh = 2'd2;
      end
      6'd29: begin
        u.post = POST_RND; u.rsel = RS_F3;
      end
      6'd30: u.post = POST_SAT;
      6'd31: begin
        u.dst = DST_PEND_SET; u.seq = SEQ_JEND; u.target = EntryTail;
      end
      6'd32: begin
        u.dst = DST_ADVANCE; u.seq = SEQ_DONE;
      end
      // Tail: last gradient element, then f
      6'd33: u.dst = DST_OUT_PEND;
      6'd34: begin
        u.dst = DST_OUT_SUM; u.seq = SEQ_DONE;
      end
      // First coordinate: (x0-1)^2 and 2*(x0-1)
      6'd35: u.ld = LD_D0SQ;
      6'd36: u.mul_en = 1'b1;
      6'd37: u.acc_en = 1'b1;
      6'd38: begin
        u.post = POST_RND; u.rsel = RS_F2;
      end
      6'd39: begin
        u.post = POST_SAT; u.ld = LD_D0_2;
      end
      6'd40: begin
        u.mul_en = 1'b1; u.dst = DST_SUM_SET;
      end
      6'd41: u.acc_en = 1'b1;
      6'd42: begin
        u.post = POST_RND; u.rsel = RS_F1;
      end
      6'd43: u.post = POST_SAT;
      6'd44: begin
        u.dst = DST_PEND_SET; u.seq = SEQ_JEND; u.target = EntryTail;
      end
      6'd45: begin
        u.dst = DST_ADVANCE; u.seq = SEQ_DONE;
      end
      default: u.seq = SEQ_DONE;
    endcase
    return u;
  endfunction

endpackage

[sv/dixon_price_value_and_gradient.sv]
// Dixon-Price value and gradient over a streamed point.
// Input channel: one beat per coordinate x_k (signed, COORD_FRAC_BITS fraction
// bits), coord_last_i set on the final coordinate of a point. Output channel:
// result beats of gradient elements (kind 0, index k) and, to close the point,
// the function value f (kind 1, last set). All results are signed Q47.16,
// saturated.
// When coordinate k >= 1 arrives, gradient element k-1 comes out; the last
// coordinate also yields the final gradient element and then f.
// Sequencing: a microcoded sequencer drives one shared 32x32 multiplier, so each
// coordinate runs as a short program; the closing beats of a point extend the
// program of its last coordinate. coord_stall_o stays high while a program
// runs, so the next coordinate is taken only once the last one is through.
// A result sits in one output register; while result_stall_i holds it, the
// sequencer waits on its next output step and nothing is dropped.
// Reset clears the sequencer, the output valid flag and the prev, index,
// pending and sum state; x, last, term and the result fields are not reset.
// A point is also closed when its coordinate count reaches MAX_COORDS.
module dixon_price_value_and_gradient
  import dpvg_pkg::*;
#(
  parameter int MAX_COORDS      = 1024,
  parameter int COORD_FRAC_BITS = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               coord_valid_i,
  output logic               coord_stall_o,
  input  logic signed [15:0] coord_value_i,
  input  logic               coord_last_i,
  output logic               result_valid_o,
  input  logic               result_stall_i,
  output logic               result_kind_o,
  output logic [9:0]         result_index_o,
  output logic signed [63:0] result_value_o,
  output logic               result_last_o
);

  localparam int IdxW  = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
  localparam int DW    = (COORD_FRAC_BITS + 2 > 17) ? COORD_FRAC_BITS + 2 : 17;
  localparam int TermW = (COORD_FRAC_BITS + 17 > 33) ? COORD_FRAC_BITS + 17 : 33;
  localparam logic signed [DW-1:0] D0Off = DW'(1) << COORD_FRAC_BITS;

  // Sequencer
  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         uw;
  logic           is_out;
  logic           out_free;
  logic           step_en;
  logic           accept;
  logic           end_pt;

  // Per-point state
  logic signed [15:0]      x_q;
  logic                    last_q;
  logic signed [15:0]      prev_q, prev_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic signed [63:0]      pend_q, pend_d;
  logic signed [63:0]      sum_q, sum_d;
  logic signed [TermW-1:0] term_q;

  // Output register
  logic               out_vld_q, out_vld_d;
  logic               out_kind_q, out_kind_d;
  logic [9:0]         out_idx_q, out_idx_d;
  logic signed [63:0] out_val_q, out_val_d;
  logic               out_last_q, out_last_d;
  logic               emit;

  // Datapath operands
  mac_ctrl_t          mac_ctrl;
  logic [63:0]        ld_a;
  logic [63:0]        ld_b;
  logic               ld_neg;
  logic [63:0]        acc_lo;
  logic signed [63:0] val;

  logic signed [16:0]      x_ext;
  logic [16:0]             x_mag;
  logic signed [DW-1:0]    d0;
  logic [DW-1:0]           d0_mag;
  logic [TermW-1:0]        t_mag;
  logic [IdxW:0]           w;
  logic signed [TermW-1:0] sq2;
  logic signed [TermW-1:0] term_d;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  assign accept   = coord_valid_i && !busy_q;
  assign uw       = ucode_rom(pc_q);
  assign out_free = !out_vld_q || !result_stall_i;
  assign end_pt   = last_q || (idx_q == IdxW'(MAX_COORDS - 1));

  always_comb begin
    case (uw.dst)
      DST_GOUT, DST_OUT_PEND, DST_OUT_SUM: is_out = 1'b1;
      default:                             is_out = 1'b0;
    endcase
  end

  // Hold the whole word while its result beat cannot be placed
  assign step_en = busy_q && (!is_out || out_free);
  assign emit    = step_en && is_out;

  assign mac_ctrl = '{
    ld_en:  step_en && (uw.ld != LD_NONE),
    mul_en: step_en && uw.mul_en,
    mul_i:  uw.mul_i,
    mul_j:  uw.mul_j,
    acc_en: step_en && uw.acc_en,
    acc_sh: uw.acc_sh,
    post:   step_en ? uw.post : POST_NONE,
    rsel:   uw.rsel
  };

  // Operand magnitudes
  assign x_ext  = 17'(x_q);
  assign x_mag  = x_ext[16] ? 17'(-x_ext) : 17'(x_ext);
  assign d0     = DW'(x_q) - D0Off;
  assign d0_mag = d0[DW-1] ? DW'(-d0) : DW'(d0);
  assign t_mag  = term_q[TermW-1] ? TermW'(-term_q) : TermW'(term_q);
  assign w      = {1'b0, idx_q} + 1'b1;

  // t = 2*x^2 - prev*2^F; acc holds x^2 here
  assign sq2    = $signed({1'b0, acc_lo[TermW-3:0], 1'b0});
  assign term_d = sq2 - (TermW'(prev_q) <<< COORD_FRAC_BITS);

  always_comb begin
    ld_a   = '0;
    ld_b   = '0;
    ld_neg = 1'b0;
    case (uw.ld)
      LD_XX: begin
        ld_a = 64'(x_mag);
        ld_b = 64'(x_mag);
      end
      LD_D0SQ: begin
        ld_a = 64'(d0_mag);
        ld_b = 64'(d0_mag);
      end
      LD_D0_2: begin
        ld_a   = 64'(d0_mag);
        ld_b   = 64'd2;
        ld_neg = d0[DW-1];
      end
      LD_T_2W: begin
        ld_a   = 64'(t_mag);
        ld_b   = 64'(w) << 1;
        ld_neg = !term_q[TermW-1];
      end
      LD_T_W: begin
        ld_a = 64'(t_mag);
        ld_b = 64'(w);
      end
      LD_TW_T: begin
        ld_a = acc_lo;
        ld_b = 64'(t_mag);
      end
      LD_X_8W: begin
        ld_a = 64'(x_mag);
        ld_b = 64'(w) << 3;
      end
      LD_XW_T: begin
        ld_a   = acc_lo;
        ld_b   = 64'(t_mag);
        ld_neg = x_q[15] ^ term_q[TermW-1];
      end
      default: begin
        ld_a   = '0;
        ld_b   = '0;
        ld_neg = 1'b0;
      end
    endcase
  end

  dpvg_mac #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .opa_i    (ld_a),
    .opb_i    (ld_b),
    .neg_i    (ld_neg),
    .acc_lo_o (acc_lo),
    .val_o    (val)
  );

  // Next state of sequencer, per-point state and output register
  always_comb begin
    busy_d     = busy_q;
    pc_d       = pc_q;
    prev_d     = prev_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    sum_d      = sum_q;
    out_vld_d  = out_vld_q;
    out_kind_d = out_kind_q;
    out_idx_d  = out_idx_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;

    // Drop the held beat once taken
    if (!result_stall_i) begin
      out_vld_d = 1'b0;
    end

    if (accept) begin
      busy_d = 1'b1;
      pc_d   = (idx_q == '0) ? EntryFirst : EntryNext;
    end else if (step_en) begin
      case (uw.seq)
        SEQ_JEND: pc_d = end_pt ? uw.target : pc_q + 1'b1;
        SEQ_DONE: busy_d = 1'b0;
        default:  pc_d = pc_q + 1'b1;
      endcase

      case (uw.dst)
        DST_GOUT: begin
          out_kind_d = 1'b0;
          out_idx_d  = 10'(idx_q - 1'b1);
          out_val_d  = sat_add(pend_q, val);
          out_last_d = 1'b0;
        end
        DST_SUM_SET:  sum_d = val;
        DST_SUM_ADD:  sum_d = sat_add(sum_q, val);
        DST_PEND_SET: pend_d = val;
        DST_ADVANCE: begin
          prev_d = x_q;
          idx_d  = idx_q + 1'b1;
        end
        DST_OUT_PEND: begin
          out_kind_d = 1'b0;
          out_idx_d  = 10'(idx_q);
          out_val_d  = pend_q;
          out_last_d = 1'b0;
        end
        DST_OUT_SUM: begin
          out_kind_d = 1'b1;
          out_idx_d  = '0;
          out_val_d  = sum_q;
          out_last_d = 1'b1;
          // Clear the point state for the next point
          prev_d     = '0;
          idx_d      = '0;
          pend_d     = '0;
          sum_d      = '0;
        end
        default: begin
          prev_d = prev_q;
        end
      endcase

      if (emit) begin
        out_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pc_q      <= '0;
      prev_q    <= '0;
      idx_q     <= '0;
      pend_q    <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      pc_q      <= pc_d;
      prev_q    <= prev_d;
      idx_q     <= idx_d;
      pend_q    <= pend_d;
      sum_q     <= sum_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= coord_value_i;
      last_q <= coord_last_i;
    end
    if (step_en && (uw.dst == DST_TERM)) begin
      term_q <= term_d;
    end
    out_kind_q <= out_kind_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign coord_stall_o  = busy_q;
  assign result_valid_o = out_vld_q;
  assign result_kind_o  = out_kind_q;
  assign result_index_o = out_idx_q;
  assign result_value_o = out_val_q;
  assign result_last_o  = out_last_q;

  // The sequencer only goes idle through a finishing step
  a_done_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(step_en && (uw.seq == SEQ_DONE)))
    else $error("sequencer went idle outside a finishing step");

  // A running program stays inside the control store
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= PcLast))
    else $error("step counter left the program");

  // The coordinate index never reaches the configured count
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IdxW+1)'(idx_q) < (IdxW+1)'(MAX_COORDS))
    else $error("coordinate index out of range");

  // Sending f leaves a clean point state and an idle sequencer
  a_point_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && (uw.dst == DST_OUT_SUM)) |=>
      ((idx_q == '0) && (sum_q == '0) && (pend_q == '0) && !busy_q))
    else $error("point state not cleared after function value");

endmodule

[sv/dpvg_mac.sv]
module dpvg_mac
  import dpvg_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 11
) (
  input  logic               clk_i,
  input  mac_ctrl_t          ctrl_i,
  input  logic [63:0]        opa_i,
  input  logic [63:0]        opb_i,
  input  logic               neg_i,
  output logic [63:0]        acc_lo_o,
  output logic signed [63:0] val_o
);

  localparam int Sh1 = COORD_FRAC_BITS - 16;
  localparam int Sh2 = 2 * COORD_FRAC_BITS - 16;
  localparam int Sh3 = 3 * COORD_FRAC_BITS - 16;
  localparam int Sh4 = 4 * COORD_FRAC_BITS - 16;

  logic [63:0]        opa_q;
  logic [63:0]        opb_q;
  logic               neg_q;
  logic [63:0]        prod_q;
  logic [127:0]       acc_q;
  logic               ovf_q;
  logic signed [63:0] val_q;

  logic [31:0]  dig_a;
  logic [31:0]  dig_b;
  logic [127:0] pp_sh;
  logic [143:0] rnd;
  logic [63:0]  lim;
  logic         over;
  logic [63:0]  mag;

  // Round half away from zero on the magnitude; negative shift scales up.
  function automatic logic [143:0] rnd_shift(input logic [127:0] a, input int sh);
    logic [143:0] w;
    w = {16'd0, a};
    if (sh > 0) begin
      w = (w + (144'd1 << (sh - 1))) >> sh;
    end else if (sh < 0) begin
      w = w << (-sh);
    end
    return w;
  endfunction

  assign dig_a = ctrl_i.mul_i ? opa_q[63:32] : opa_q[31:0];
  assign dig_b = ctrl_i.mul_j ? opb_q[63:32] : opb_q[31:0];

  always_comb begin
    case (ctrl_i.acc_sh)
      2'd1:    pp_sh = {32'd0, prod_q, 32'd0};
      2'd2:    pp_sh = {prod_q, 64'd0};
      default: pp_sh = {64'd0, prod_q};
    endcase
  end

  always_comb begin
    case (ctrl_i.rsel)
      RS_F1:   rnd = rnd_shift(acc_q, Sh1);
      RS_F2:   rnd = rnd_shift(acc_q, Sh2);
      RS_F3:   rnd = rnd_shift(acc_q, Sh3);
      RS_F4:   rnd = rnd_shift(acc_q, Sh4);
      default: rnd = rnd_shift(acc_q, Sh1);
    endcase
  end

  // Clamp to the signed 64-bit range, then apply the sign
  assign lim  = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  assign over = ovf_q || (|acc_q[127:64]) || (acc_q[63:0] > lim);
  assign mag  = over ? lim : acc_q[63:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_en) begin
      opa_q <= opa_i;
      opb_q <= opb_i;
      neg_q <= neg_i;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= {32'd0, dig_a} * {32'd0, dig_b};
    end
    if (ctrl_i.ld_en) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + pp_sh;
    end else if (ctrl_i.post == POST_RND) begin
      acc_q <= rnd[127:0];
      ovf_q <= |rnd[143:128];
    end
    if (ctrl_i.post == POST_SAT) begin
      val_q <= neg_q ? $signed(-mag) : $signed(mag);
    end
  end

  assign acc_lo_o = acc_q[63:0];
  assign val_o    = val_q;

endmodule

[bench/tb_dixon_price_value_and_gradient.sv]
`timescale 1ns / 100ps

module tb_dixon_price_value_and_gradient;

  localparam int MaxCoords = 1024;
  localparam int FracBits  = 11;

  // Result kinds on the output channel
  localparam logic KindGrad  = 1'b0;
  localparam logic KindValue = 1'b1;

  // Q4.11 corners: plus ten, minus ten and one
  localparam logic signed [15:0] CoordTen    = 16'sd20480;
  localparam logic signed [15:0] CoordNegTen = -16'sd20480;
  localparam logic signed [15:0] CoordOne    = 16'sd2048;

  localparam int RandomCoords = 150;
  // Worst case per coordinate: its busy program, three results each stalled and
  // a sender gap, over roughly 220 coordinates; take the limit many times over.
  localparam int CycleLimit = 100000;
  localparam int DrainCycles = 60;

  typedef struct {
    logic        kind;
    logic [9:0]  index;
    longint      value;
    logic        last;
  } result_beat_t;

  // One row of the directed table. Rows with known_vals carry g0 and f typed
  // in by hand (single-coordinate points only); the rest use the predictor.
  typedef struct {
    logic signed [15:0] value;
    bit                 last;
    bit                 known_vals;
    longint             g0;
    longint             f;
  } coord_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               coord_valid_i;
  logic               coord_stall_o;
  logic signed [15:0] coord_value_i;
  logic               coord_last_i;
  logic               result_valid_o;
  logic               result_stall_i;
  logic               result_kind_o;
  logic [9:0]         result_index_o;
  logic signed [63:0] result_value_o;
  logic               result_last_o;

  dixon_price_value_and_gradient #(
    .MAX_COORDS      (MaxCoords),
    .COORD_FRAC_BITS (FracBits)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .coord_valid_i  (coord_valid_i),
    .coord_stall_o  (coord_stall_o),
    .coord_value_i  (coord_value_i),
    .coord_last_i   (coord_last_i),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .result_kind_o  (result_kind_o),
    .result_index_o (result_index_o),
    .result_value_o (result_value_o),
    .result_last_o  (result_last_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: one point in flight
  // ---------------------------------------------------------------------------
  longint       prev_x;       // previous coordinate, raw Q4.11
  longint       grad_carry;   // part of the next gradient element already known
  longint       f_sum;        // function value so far, Q.16
  int           coord_idx;    // index of the coordinate expected next
  result_beat_t step_beats [3];

  result_beat_t results_due [$];

  int  errors = 0;
  int  results_checked = 0;
  int  coords_sent = 0;
  int  points_closed = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;           // when set, neither side inserts idle cycles

  // Form a*b exactly, round to nearest (ties away from zero) after dropping
  // sh bits (a negative sh shifts left), then clamp to 64 bits.
  function automatic longint round_q16(input longint a, input longint b, input int sh);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] prod;
    logic [127:0]        mag;
    logic [127:0]        lim;
    logic                neg;
    wa   = a;
    wb   = b;
    prod = wa * wb;
    neg  = prod[127];
    mag  = neg ? -prod : prod;
    if (sh > 0) begin
      mag = (mag + (128'd1 << (sh - 1))) >> sh;
    end else if (sh < 0) begin
      mag = mag << (-sh);
    end
    lim = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
    if (mag > lim) mag = lim;
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic longint add_sat(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(signed'(a)) + 65'(signed'(b));
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s[63:0]);
  endfunction

  function automatic void clear_point();
    prev_x     = 0;
    grad_carry = 0;
    f_sum      = 0;
    coord_idx  = 0;
  endfunction

  // Advance the point by one coordinate; fill step_beats with the results it
  // releases and return how many.
  function automatic int dixon_price_step(input logic signed [15:0] xv, input bit last_flag);
    longint x;
    longint d0;
    longint w;
    longint t;
    longint g;
    int     n;
    x = xv;
    n = 0;
    if (coord_idx == 0) begin
      d0         = x - (64'sd1 << FracBits);
      f_sum      = round_q16(d0, d0, 2 * FracBits - 16);
      grad_carry = round_q16(d0, 2, FracBits - 16);
    end else begin
      w = coord_idx + 1;
      // t_k = 2*x_k^2 - x_{k-1}, exact at scale 2^(2F)
      t = 2 * x * x - prev_x * (64'sd1 << FracBits);
      g = add_sat(grad_carry, round_q16(t, -2 * w, 2 * FracBits - 16));
      step_beats[n] = '{KindGrad, 10'(coord_idx - 1), g, 1'b0};
      n++;
      f_sum      = add_sat(f_sum, round_q16(t * w, t, 4 * FracBits - 16));
      grad_carry = round_q16(x * 8 * w, t, 3 * FracBits - 16);
    end
    // Close on the flag, or when the coordinate count hits the cap
    if (last_flag || coord_idx + 1 >= MaxCoords) begin
      step_beats[n] = '{KindGrad, 10'(coord_idx), grad_carry, 1'b0};
      n++;
      step_beats[n] = '{KindValue, 10'd0, f_sum, 1'b1};
      n++;
      points_closed++;
      clear_point();
    end else begin
      prev_x    = x;
      coord_idx = coord_idx + 1;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one coordinate beat, with a random lead-in gap
  // ---------------------------------------------------------------------------
  task automatic send_coord(input logic signed [15:0] value, input bit last_flag,
                            input bit known_vals, input longint g0, input longint f);
    int gap;
    int n;
    gap = calm ? 0 : $urandom_range(0, 3);
    // Drop valid only when a gap is wanted, so a back-to-back beat keeps it high
    if (gap > 0) begin
      coord_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    coord_valid_i <= 1'b1;
    coord_value_i <= value;
    coord_last_i  <= last_flag;
    // Hold the beat until the block takes it
    do @(posedge clk_i); while (coord_stall_o);
    n = dixon_price_step(value, last_flag);
    if (known_vals) begin
      step_beats[0].value = g0;
      step_beats[1].value = f;
    end
    for (int i = 0; i < n; i++) results_due.push_back(step_beats[i]);
    coords_sent++;
  endtask

  // Wait out every outstanding result before the next beat goes in
  task automatic drain_results();
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'(int'($urandom_range(0, 40960)) - 20480);
    if (r == 7) begin
      case ($urandom_range(0, 4))
        0:       return CoordTen;
        1:       return CoordNegTen;
        2:       return CoordOne;
        3:       return -CoordOne;
        default: return 16'sd0;
      endcase
    end
    // Anything the 16 bits allow, out-of-range values included
    return 16'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall ahead of every result beat
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    result_stall_i = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        result_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      result_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(result_valid_o && !result_stall_i));
    end
  end

  // Check every accepted result beat against the oldest expectation
  always @(posedge clk_i) begin
    result_beat_t exp_beat;
    if (rst_ni && result_valid_o && !result_stall_i) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result beat kind %0d index %0d value %0d", $time,
                 result_kind_o, result_index_o, result_value_o);
        errors++;
      end else begin
        exp_beat = results_due.pop_front();
        results_checked++;
        if (result_kind_o !== exp_beat.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time,
                   exp_beat.kind, result_kind_o);
          errors++;
        end
        if (result_index_o !== exp_beat.index) begin
          $display("%0t: result_index expected %0d actual %0d", $time,
                   exp_beat.index, result_index_o);
          errors++;
        end
        if (result_value_o !== exp_beat.value) begin
          $display("%0t: result_value expected %0d actual %0d", $time,
                   exp_beat.value, result_value_o);
          errors++;
        end
        if (result_last_o !== exp_beat.last) begin
          $display("%0t: result_last expected %0d actual %0d", $time,
                   exp_beat.last, result_last_o);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               results_due.size());
      $display("tb_dixon_price_value_and_gradient failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  coord_row_t directed_rows [24];

  initial begin
    // Single-coordinate points: g0 = 2*(x0-1), f = (x0-1)^2, typed in
    directed_rows[0]  = '{CoordOne,      1'b1, 1'b1, 0,        0};
    directed_rows[1]  = '{16'sd0,        1'b1, 1'b1, -131072,  65536};
    directed_rows[2]  = '{CoordTen,      1'b1, 1'b1, 1179648,  5308416};
    directed_rows[3]  = '{CoordNegTen,   1'b1, 1'b1, -1441792, 7929856};
    // Full 16-bit extremes, out of the nominal range
    directed_rows[4]  = '{16'sh7FFF,     1'b1, 1'b0, 0, 0};
    directed_rows[5]  = '{16'sh8000,     1'b1, 1'b0, 0, 0};
    // Two-coordinate points across the corners
    directed_rows[6]  = '{CoordNegTen,   1'b0, 1'b0, 0, 0};
    directed_rows[7]  = '{CoordTen,      1'b1, 1'b0, 0, 0};
    directed_rows[8]  = '{CoordTen,      1'b0, 1'b0, 0, 0};
    directed_rows[9]  = '{CoordNegTen,   1'b1, 1'b0, 0, 0};
    directed_rows[10] = '{16'sh7FFF,     1'b0, 1'b0, 0, 0};
    directed_rows[11] = '{16'sh8000,     1'b1, 1'b0, 0, 0};
    // Most negative value repeated: largest terms
    directed_rows[12] = '{16'sh8000,     1'b0, 1'b0, 0, 0};
    directed_rows[13] = '{16'sh8000,     1'b0, 1'b0, 0, 0};
    directed_rows[14] = '{16'sh8000,     1'b1, 1'b0, 0, 0};
    // All zeros
    directed_rows[15] = '{16'sd0,        1'b0, 1'b0, 0, 0};
    directed_rows[16] = '{16'sd0,        1'b0, 1'b0, 0, 0};
    directed_rows[17] = '{16'sd0,        1'b1, 1'b0, 0, 0};
    // Single-LSB values, one, two and one LSB under one, feeding the rounding
    directed_rows[18] = '{16'sd1,        1'b0, 1'b0, 0, 0};
    directed_rows[19] = '{-16'sd1,       1'b0, 1'b0, 0, 0};
    directed_rows[20] = '{CoordOne,      1'b0, 1'b0, 0, 0};
    directed_rows[21] = '{16'sd4096,     1'b1, 1'b0, 0, 0};
    directed_rows[22] = '{16'sd2047,     1'b0, 1'b0, 0, 0};
    directed_rows[23] = '{-16'sd1,       1'b1, 1'b0, 0, 0};
  end

  initial begin
    int len;
    int rnd_sent;
    int r;
    coord_valid_i = 1'b0;
    coord_value_i = '0;
    coord_last_i  = 1'b0;
    rst_ni        = 1'b0;
    clear_point();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      send_coord(directed_rows[i].value, directed_rows[i].last,
                 directed_rows[i].known_vals, directed_rows[i].g0, directed_rows[i].f);
    end

    // Hold the sender until the block has emptied its results
    coord_valid_i <= 1'b0;
    drain_results();

    // Random points: mostly short, some medium, a few long
    rnd_sent = 0;
    while (rnd_sent < RandomCoords) begin
      calm = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 9);
      if (r < 5) len = $urandom_range(1, 4);
      else if (r < 8) len = $urandom_range(5, 12);
      else len = $urandom_range(13, 40);
      for (int i = 0; i < len; i++) begin
        send_coord(pick_coord(), (i == len - 1), 1'b0, 0, 0);
      end
      rnd_sent += len;
    end
    calm = 1'b0;

    coord_valid_i <= 1'b0;
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d coordinates in %0d points: directed corners, full 16-bit",
             coords_sent, points_closed);
    $display("extremes and random point lengths; checked %0d result beats under gaps and stalls",
             results_checked);
    if (errors == 0) begin
      $display("tb_dixon_price_value_and_gradient passed");
    end else begin
      $display("tb_dixon_price_value_and_gradient failed");
    end
    $finish;
  end

endmodule

[dixon_price_value_and_gradient.f]
sv/dpvg_pkg.sv
sv/dpvg_mac.sv
sv/dixon_price_value_and_gradient.sv
bench/tb_dixon_price_value_and_gradient.sv
